@@ hw/rtl/clock_page_replacer_unit_assert.svh @@
// Assertion macros used by the checker.
`ifndef CLOCK_PAGE_REPLACER_UNIT_ASSERT_SVH
`define CLOCK_PAGE_REPLACER_UNIT_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define CPR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define CPR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/cpr_pkg.sv @@
package cpr_pkg;

    localparam int FRAME_W        = 6;
    localparam int COUNT_W        = 7;
    localparam int CAP_W          = 7;
    localparam int NUM_FRAMES_DEF = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // widest frame-table index over the supported frame counts (up to 1024)
    localparam int TBL_IDX_W = 10;

    localparam logic [1:0] OP_VICTIM = 2'd0;
    localparam logic [1:0] OP_PIN    = 2'd1;
    localparam logic [1:0] OP_UNPIN  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [FRAME_W-1:0] frame;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] chosen_frame;
        logic [COUNT_W-1:0] count;
    } out_item_t;

    typedef struct packed {
        logic                 clr_pres_a;
        logic                 clr_ref_a;
        logic                 set_b;
        logic [TBL_IDX_W-1:0] idx_a;
        logic [TBL_IDX_W-1:0] idx_b;
    } tbl_cmd_t;

    typedef struct packed {
        logic pres_a;
        logic ref_a;
        logic pres_b;
    } tbl_stat_t;

endpackage

@@ hw/rtl/cpr_frame_table.sv @@
module cpr_frame_table #(
    parameter int NUM_FRAMES = cpr_pkg::NUM_FRAMES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cpr_pkg::tbl_cmd_t cmd,
    output cpr_pkg::tbl_stat_t stat
);

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

    logic [NUM_FRAMES-1:0] present_reg;
    logic [NUM_FRAMES-1:0] ref_reg;
    logic [IDX_W-1:0]      idx_a;
    logic [IDX_W-1:0]      idx_b;

    assign idx_a = cmd.idx_a[IDX_W-1:0];
    assign idx_b = cmd.idx_b[IDX_W-1:0];

    assign stat.pres_a = present_reg[idx_a];
    assign stat.ref_a  = ref_reg[idx_a];
    assign stat.pres_b = present_reg[idx_b];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            ref_reg     <= '0;
        end else begin
            if (cmd.clr_pres_a) begin
                present_reg[idx_a] <= 1'b0;
            end
            if (cmd.clr_ref_a) begin
                ref_reg[idx_a] <= 1'b0;
            end
            if (cmd.set_b) begin
                present_reg[idx_b] <= 1'b1;
                ref_reg[idx_b]     <= 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/clock_page_replacer_unit.sv @@
// Pin, unpin without eviction, empty victim and ignored items pass from the input transfer through
// the exec state to the result; a victim or a forced eviction adds a sweep in which the hand visits
// at most 2*NUM_FRAMES frame slots before the result is shown.
// One item at a time; the next can be taken in the cycle after the result transfer.
// The sweep checks one slot per cycle through the shared frame-table port.
// Reset (aresetn, synchronous, active low): no candidates, hand 0, capacity 64.
module clock_page_replacer_unit #(
    parameter int NUM_FRAMES = cpr_pkg::NUM_FRAMES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  cpr_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output cpr_pkg::out_item_t        m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cpr_pkg::CAP_W-1:0] cfg_data
);

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int CMP_W = (CNT_W > cpr_pkg::CAP_W) ? CNT_W : cpr_pkg::CAP_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]                  state_reg, state_next;
    cpr_pkg::in_item_t           item_reg, item_next;
    logic [IDX_W-1:0]            hand_reg, hand_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [cpr_pkg::CAP_W-1:0]   cap_reg, cap_next;
    cpr_pkg::out_item_t          res_reg, res_next;

    cpr_pkg::tbl_cmd_t           cmd;
    cpr_pkg::tbl_stat_t          stat;

    logic                        frame_ok;
    logic                        full;
    logic [cpr_pkg::CAP_W-1:0]   cap_eff;

    cpr_frame_table #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_table (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .stat   (stat)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_data    = res_reg;
    assign cfg_ready = 1'b1;

    assign frame_ok = (32'(item_reg.frame) < NUM_FRAMES);
    assign cap_eff  = (cap_reg == '0) ? cpr_pkg::CAP_W'(1) : cap_reg;
    assign full     = (CMP_W'(count_reg) >= CMP_W'(cap_eff)) && (count_reg != '0);

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        hand_next  = hand_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        res_next   = res_reg;

        cmd            = '0;
        cmd.idx_a      = cpr_pkg::TBL_IDX_W'(item_reg.frame);
        cmd.idx_b      = cpr_pkg::TBL_IDX_W'(item_reg.frame);

        if (cfg_valid) begin
            cap_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_OUT;
                case (item_reg.op)
                    cpr_pkg::OP_VICTIM: begin
                        if (count_reg != '0) begin
                            state_next = ST_SWEEP;
                        end
                    end
                    cpr_pkg::OP_PIN: begin
                        if (frame_ok && stat.pres_b) begin
                            cmd.clr_pres_a = 1'b1;
                            cmd.clr_ref_a  = 1'b1;
                            count_next     = count_reg - CNT_W'(1);
                        end
                    end
                    cpr_pkg::OP_UNPIN: begin
                        if (frame_ok && !stat.pres_b) begin
                            if (full) begin
                                state_next = ST_SWEEP;
                            end else begin
                                cmd.set_b  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                res_next.found        = 1'b0;
                res_next.chosen_frame = '0;
                res_next.count        = cpr_pkg::COUNT_W'(count_next);
            end
            ST_SWEEP: begin
                cmd.idx_a = cpr_pkg::TBL_IDX_W'(hand_reg);
                hand_next = (hand_reg == IDX_W'(NUM_FRAMES - 1)) ? '0 : hand_reg + IDX_W'(1);
                if (stat.pres_a) begin
                    if (stat.ref_a) begin
                        cmd.clr_ref_a = 1'b1;
                    end else begin
                        cmd.clr_pres_a = 1'b1;
                        // unpin that forced the eviction takes the freed place
                        if (item_reg.op == cpr_pkg::OP_UNPIN) begin
                            cmd.set_b  = 1'b1;
                            count_next = count_reg;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        res_next.found        = 1'b1;
                        res_next.chosen_frame = cpr_pkg::FRAME_W'(hand_reg);
                        res_next.count        = cpr_pkg::COUNT_W'(count_next);
                        state_next            = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hand_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= cpr_pkg::CAP_RESET;
        end else begin
            state_reg <= state_next;
            hand_reg  <= hand_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

endmodule

@@ hw/rtl/cpr_checker.sv @@
`include "clock_page_replacer_unit_assert.svh"

module cpr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input cpr_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input cpr_pkg::out_item_t m_data
);

    logic s_xfer;
    logic m_xfer;

    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;

    // held result stays put until taken
    `CPR_ASSERT_NEXT(a_res_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // one item in flight: never ready for input while a result is shown
    `CPR_ASSERT_IMPLY(a_one_item, aclk, aresetn, m_valid, !s_ready)
    // an accepted item keeps the block busy, with nothing shown, before any result appears
    `CPR_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_xfer, !s_ready && !m_valid)
    // after a result transfer the block is ready again
    `CPR_ASSERT_NEXT(a_ready_after_out, aclk, aresetn, m_xfer, s_ready && !m_valid)
    // reset leaves the block ready with nothing to show
    `CPR_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, s_ready && !m_valid)

endmodule

bind clock_page_replacer_unit cpr_checker u_cpr_checker (.*);

@@ tb/sv/clock_page_replacer_unit_tb.sv @@
`timescale 1ns / 1ps

module clock_page_replacer_unit_tb;

    localparam int FRAMES       = cpr_pkg::NUM_FRAMES_DEF;
    localparam int DRAIN_CYCLES = 2 * FRAMES + 16;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    cpr_pkg::in_item_t          s_data    = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    cpr_pkg::out_item_t         m_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [cpr_pkg::CAP_W-1:0]  cfg_data  = '0;

    clock_page_replacer_unit #(
        .NUM_FRAMES(FRAMES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("clock_page_replacer_unit_tb failed");
        $finish;
    end

    // replacement state mirror
    bit                          cand_present [FRAMES];
    bit                          ref_bit      [FRAMES];
    logic [cpr_pkg::FRAME_W-1:0] sweep_hand  = '0;
    int                          cand_count   = 0;
    logic [cpr_pkg::CAP_W-1:0]   cap_reg      = cpr_pkg::CAP_RESET;

    cpr_pkg::out_item_t pending_results [$];
    cpr_pkg::out_item_t want;

    int send_idle       = 35;
    int recv_idle       = 51;
    int mismatches      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int victims_found   = 0;
    int forced_evicts   = 0;

    function automatic logic [cpr_pkg::FRAME_W-1:0] sweep_out_frame();
        logic [cpr_pkg::FRAME_W-1:0] slot;
        for (int i = 0; i < 2 * FRAMES + 1; i++) begin
            slot       = sweep_hand;
            sweep_hand = slot + 1'b1;
            if (cand_present[slot]) begin
                if (ref_bit[slot]) begin
                    ref_bit[slot] = 1'b0;
                end else begin
                    cand_present[slot] = 1'b0;
                    cand_count--;
                    return slot;
                end
            end
        end
        return '0;
    endfunction

    function automatic cpr_pkg::out_item_t predict_replacer(cpr_pkg::in_item_t it);
        cpr_pkg::out_item_t r;
        int                 cap_eff;
        r       = '0;
        cap_eff = (cap_reg == '0) ? 1 : int'(cap_reg);
        case (it.op)
            cpr_pkg::OP_VICTIM: begin
                if (cand_count > 0) begin
                    r.chosen_frame = sweep_out_frame();
                    r.found        = 1'b1;
                    victims_found++;
                end
            end
            cpr_pkg::OP_PIN: begin
                if (cand_present[it.frame]) begin
                    cand_present[it.frame] = 1'b0;
                    ref_bit[it.frame]      = 1'b0;
                    cand_count--;
                end
            end
            cpr_pkg::OP_UNPIN: begin
                if (!cand_present[it.frame]) begin
                    if (cand_count >= cap_eff && cand_count > 0) begin
                        r.chosen_frame = sweep_out_frame();
                        r.found        = 1'b1;
                        forced_evicts++;
                    end
                    cand_present[it.frame] = 1'b1;
                    ref_bit[it.frame]      = 1'b1;
                    cand_count++;
                end
            end
            default: ;
        endcase
        r.count = cpr_pkg::COUNT_W'(cand_count);
        return r;
    endfunction

    task automatic send_op(logic [1:0] op, logic [cpr_pkg::FRAME_W-1:0] frame);
        cpr_pkg::in_item_t  it;
        cpr_pkg::out_item_t exp_res;
        it.op    = op;
        it.frame = frame;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        exp_res = predict_replacer(it);
        pending_results.insert(pending_results.size(), exp_res);
        items_sent++;
    endtask

    // only while idle: all results back, then a short pause
    task automatic write_capacity(logic [cpr_pkg::CAP_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_reg = value;
        cfg_writes++;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transfer: found %0d chosen_frame %0d count %0d",
                       m_data.found, m_data.chosen_frame, m_data.count);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_data.found);
                    mismatches++;
                end
                if (m_data.chosen_frame !== want.chosen_frame) begin
                    $error("chosen_frame: expected %0d, got %0d",
                           want.chosen_frame, m_data.chosen_frame);
                    mismatches++;
                end
                if (m_data.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, m_data.count);
                    mismatches++;
                end
                results_checked++;
            end
        end
    end

    task automatic test_empty_and_ignored();
        send_op(cpr_pkg::OP_VICTIM, 6'd0);
        send_op(cpr_pkg::OP_PIN, 6'd0);
        send_op(2'd3, 6'h3F);
        send_op(cpr_pkg::OP_UNPIN, 6'd63);
        send_op(cpr_pkg::OP_UNPIN, 6'd63);
        send_op(cpr_pkg::OP_PIN, 6'd63);
        send_op(cpr_pkg::OP_VICTIM, 6'h2A);
    endtask

    task automatic test_forced_eviction();
        write_capacity(7'd2);
        send_op(cpr_pkg::OP_UNPIN, 6'd0);
        send_op(cpr_pkg::OP_UNPIN, 6'd1);
        send_op(cpr_pkg::OP_UNPIN, 6'd2);
        // zero behaves as one; count already above it
        write_capacity(7'd0);
        send_op(cpr_pkg::OP_UNPIN, 6'd10);
        write_capacity(7'd127);
        send_op(cpr_pkg::OP_UNPIN, 6'd20);
        send_op(cpr_pkg::OP_UNPIN, 6'd21);
        send_op(cpr_pkg::OP_UNPIN, 6'd63);
    endtask

    task automatic test_victim_sweep();
        send_op(cpr_pkg::OP_VICTIM, 6'd0);
        send_op(cpr_pkg::OP_PIN, 6'd21);
        send_op(cpr_pkg::OP_PIN, 6'd5);
        send_op(cpr_pkg::OP_VICTIM, 6'h3F);
        send_op(cpr_pkg::OP_VICTIM, 6'd0);
        send_op(cpr_pkg::OP_VICTIM, 6'd0);
        send_op(cpr_pkg::OP_VICTIM, 6'd0);
        send_op(cpr_pkg::OP_VICTIM, 6'd0);
    endtask

    // pool keeps pins and repeat unpins hitting frames that are present
    task automatic test_random_traffic(int n_items, int unpin_pct);
        logic [cpr_pkg::FRAME_W-1:0] pool_base;
        logic [cpr_pkg::FRAME_W-1:0] frame;
        logic [1:0]                  op;
        int                          r;
        pool_base = cpr_pkg::FRAME_W'($urandom_range(63));
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < unpin_pct)                              op = cpr_pkg::OP_UNPIN;
            else if (r < unpin_pct + (100 - unpin_pct) / 2) op = cpr_pkg::OP_VICTIM;
            else if (r < 97)                                op = cpr_pkg::OP_PIN;
            else                                            op = 2'd3;
            if ($urandom_range(99) < 65) begin
                frame = pool_base + cpr_pkg::FRAME_W'($urandom_range(15));
            end else begin
                frame = cpr_pkg::FRAME_W'($urandom_range(63));
            end
            send_op(op, frame);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 35;
        recv_idle = 51;
        test_empty_and_ignored();
        test_forced_eviction();
        test_victim_sweep();
        write_capacity(7'd4);
        test_random_traffic(70, 45);
        write_capacity(7'd1);
        test_random_traffic(60, 45);

        send_idle = 51;
        recv_idle = 35;
        write_capacity(7'd16);
        test_random_traffic(70, 50);
        write_capacity(7'd0);
        test_random_traffic(60, 45);

        send_idle = 0;
        recv_idle = 0;
        write_capacity(7'd64);
        test_random_traffic(80, 80);
        write_capacity(cpr_pkg::CAP_W'($urandom_range(1, 64)));
        test_random_traffic(60, 45);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items and %0d capacity writes; %0d results checked",
                 items_sent, cfg_writes, results_checked);
        $display("victims returned %0d, evictions forced by unpin %0d",
                 victims_found, forced_evicts);
        if (mismatches == 0) begin
            $display("clock_page_replacer_unit_tb passed");
        end else begin
            $display("clock_page_replacer_unit_tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_frame_table.sv
hw/rtl/clock_page_replacer_unit.sv
hw/rtl/cpr_checker.sv
tb/sv/clock_page_replacer_unit_tb.sv
